// ----- design/stli_pkg.sv -----
// ----------------------------------------------------------------------------
// stli_pkg
// Shared codes and types for the sorted table linear interpolator: command
// and status codes, the insert broadcast and the query token of the cell row.
// ----------------------------------------------------------------------------
package stli_pkg;

    localparam int FIELD_W = 16;

    localparam logic [1:0] CMD_CLEAR  = 2'd0;
    localparam logic [1:0] CMD_INSERT = 2'd1;
    localparam logic [1:0] CMD_QUERY  = 2'd2;
    localparam logic [1:0] CMD_NOP    = 2'd3;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_RANGE = 2'd1;
    localparam logic [1:0] ST_FULL  = 2'd2;

    // Point broadcast to every cell during an insert.
    typedef struct packed {
        logic                       en;
        logic signed [FIELD_W-1:0]  angle;
        logic signed [FIELD_W-1:0]  lift;
    } ins_t;

    // Query token handed from cell to cell.
    typedef struct packed {
        logic signed [FIELD_W-1:0]  q;
        logic                       done;
        logic                       match;
        logic                       has_prev;
        logic signed [FIELD_W-1:0]  a_lo;
        logic signed [FIELD_W-1:0]  l_lo;
        logic signed [FIELD_W-1:0]  a_hi;
        logic signed [FIELD_W-1:0]  l_hi;
    } tok_t;

endpackage

// ----- design/stli_cell.sv -----
// ----------------------------------------------------------------------------
// stli_cell
// One table slot: holds a point, takes part in the sorted shift-insert and
// advances the query token by one slot per cycle.
// ----------------------------------------------------------------------------
module stli_cell (
    input  logic                               clk,
    input  logic                               valid,
    input  logic                               left_le,
    input  logic signed [stli_pkg::FIELD_W-1:0] left_angle,
    input  logic signed [stli_pkg::FIELD_W-1:0] left_lift,
    input  stli_pkg::ins_t                     ins,
    input  stli_pkg::tok_t                     tok_in,
    output logic                               le,
    output logic signed [stli_pkg::FIELD_W-1:0] angle,
    output logic signed [stli_pkg::FIELD_W-1:0] lift,
    output stli_pkg::tok_t                     tok_out
);
    import stli_pkg::*;

    logic signed [FIELD_W-1:0] angle_reg;
    logic signed [FIELD_W-1:0] lift_reg;
    logic signed [FIELD_W-1:0] angle_next;
    logic signed [FIELD_W-1:0] lift_next;
    tok_t                      tok_reg;
    tok_t                      tok_next;

    // Cells whose angle is not above the new one form a prefix; they hold.
    assign le = valid && (angle_reg <= ins.angle);

    always_comb
    begin
        angle_next = angle_reg;
        lift_next  = lift_reg;
        if (ins.en && !le)
        begin
            if (left_le)
            begin
                angle_next = ins.angle;
                lift_next  = ins.lift;
            end
            else
            begin
                angle_next = left_angle;
                lift_next  = left_lift;
            end
        end
    end

    always_comb
    begin
        tok_next = tok_in;
        if (!tok_in.done && valid)
        begin
            if (angle_reg == tok_in.q)
            begin
                tok_next.done  = 1'b1;
                tok_next.match = 1'b1;
                tok_next.l_lo  = lift_reg;
            end
            else if (angle_reg > tok_in.q)
            begin
                tok_next.done = 1'b1;
                tok_next.a_hi = angle_reg;
                tok_next.l_hi = lift_reg;
            end
            else
            begin
                tok_next.has_prev = 1'b1;
                tok_next.a_lo     = angle_reg;
                tok_next.l_lo     = lift_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        angle_reg <= angle_next;
        lift_reg  <= lift_next;
        tok_reg   <= tok_next;
    end

    assign angle   = angle_reg;
    assign lift    = lift_reg;
    assign tok_out = tok_reg;

endmodule

// ----- design/sorted_table_linear_interpolator_top.sv -----
// ----------------------------------------------------------------------------
// sorted_table_linear_interpolator_top
// Sorted angle/lift table with clear, insert and interpolating query.
// ----------------------------------------------------------------------------
// Usage: one item in (command, angle, lift_value) gives one item out
// (status, lift_result, entry_total). Both channels move an item at a clock
// edge where valid is high and stall is low.
// Clear, insert and no-op items finish in the accept cycle: the result item
// is registered and valid in the next cycle, so they can follow back to
// back. A query token walks the row of TABLE_DEPTH cells, one cell per
// cycle; then the product is formed, the magnitude is prepared and a
// restoring divider works out the quotient one bit at a time. An exact
// match or an out-of-range query skips the divide. One item is in work at a
// time. Reset empties the table and the output register. Stored points are
// not cleared; only slots below the point count take part in any lookup.
// When the receiver stalls, the result item holds in the output register and
// the next item is not taken until that register frees up.
// ----------------------------------------------------------------------------
module sorted_table_linear_interpolator_top #(
    parameter int TABLE_DEPTH = 16
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    output logic                                in_stall,
    input  logic [1:0]                          command,
    input  logic signed [stli_pkg::FIELD_W-1:0] angle,
    input  logic signed [stli_pkg::FIELD_W-1:0] lift_value,
    output logic                                out_valid,
    input  logic                                out_stall,
    output logic [1:0]                          status,
    output logic signed [stli_pkg::FIELD_W-1:0] lift_result,
    output logic [4:0]                          entry_total
);
    import stli_pkg::*;

    localparam int CNT_W  = $clog2(TABLE_DEPTH + 1);
    localparam int WALK_W = $clog2(TABLE_DEPTH);
    localparam int DIV_W  = $clog2(FIELD_W);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_WALK = 3'd1;
    localparam logic [2:0] S_MUL  = 3'd2;
    localparam logic [2:0] S_PREP = 3'd3;
    localparam logic [2:0] S_DIV  = 3'd4;
    localparam logic [2:0] S_FIN  = 3'd5;

    logic [2:0]                state_reg;
    logic [2:0]                state_next;
    logic [CNT_W-1:0]          count_reg;
    logic [CNT_W-1:0]          count_next;
    logic [WALK_W-1:0]         walk_reg;
    logic [WALK_W-1:0]         walk_next;
    logic [DIV_W-1:0]          step_reg;
    logic [DIV_W-1:0]          step_next;
    logic signed [FIELD_W-1:0] q_reg;
    logic signed [33:0]        prod_reg;
    logic [FIELD_W-1:0]        den_reg;
    logic [FIELD_W-1:0]        rem_reg;
    logic [FIELD_W-1:0]        quo_reg;
    logic                      neg_reg;
    logic signed [FIELD_W-1:0] base_reg;
    logic [1:0]                res_st_reg;

    logic                      out_valid_reg;
    logic [1:0]                status_reg;
    logic signed [FIELD_W-1:0] lift_reg;
    logic [4:0]                total_reg;

    logic                      in_acc;
    logic                      out_free;
    logic                      full;
    ins_t                      ins;
    tok_t                      tok_head;
    tok_t                      tok_end;

    tok_t                      tok [0:TABLE_DEPTH];
    logic                      le_chain [0:TABLE_DEPTH];
    logic signed [FIELD_W-1:0] ang_chain [0:TABLE_DEPTH];
    logic signed [FIELD_W-1:0] lift_chain [0:TABLE_DEPTH];
    logic [TABLE_DEPTH-1:0]    slot_valid;

    logic signed [16:0]        dq;
    logic signed [16:0]        dl;
    logic signed [16:0]        dden;
    logic signed [33:0]        prod_w;
    logic [33:0]               mag;
    logic [16:0]               trial;
    logic [16:0]               shifted;
    logic [FIELD_W-1:0]        quo_signed;

    assign out_free = !out_valid_reg || !out_stall;
    assign in_stall = !((state_reg == S_IDLE) && out_free);
    assign in_acc   = in_valid && !in_stall;
    assign full     = (count_reg == CNT_W'(TABLE_DEPTH));

    assign ins.en    = in_acc && (command == CMD_INSERT) && !full;
    assign ins.angle = angle;
    assign ins.lift  = lift_value;

    always_comb
    begin
        tok_head          = '0;
        tok_head.q        = q_reg;
    end

    // Left edge of the row: the new point lands in slot 0 when nothing is below.
    assign tok[0]        = tok_head;
    assign le_chain[0]   = 1'b1;
    assign ang_chain[0]  = angle;
    assign lift_chain[0] = lift_value;

    genvar gi;
    generate
        for (gi = 0; gi < TABLE_DEPTH; gi++)
        begin : g_cell
            assign slot_valid[gi] = (CNT_W'(gi) < count_reg);

            stli_cell u_cell (
                .clk        (clk),
                .valid      (slot_valid[gi]),
                .left_le    (le_chain[gi]),
                .left_angle (ang_chain[gi]),
                .left_lift  (lift_chain[gi]),
                .ins        (ins),
                .tok_in     (tok[gi]),
                .le         (le_chain[gi+1]),
                .angle      (ang_chain[gi+1]),
                .lift       (lift_chain[gi+1]),
                .tok_out    (tok[gi+1])
            );
        end
    endgenerate

    assign tok_end = tok[TABLE_DEPTH];

    // Bracket arithmetic: all differences are positive except the lift step.
    assign dq     = {tok_end.q[FIELD_W-1], tok_end.q}
                  - {tok_end.a_lo[FIELD_W-1], tok_end.a_lo};
    assign dl     = {tok_end.l_hi[FIELD_W-1], tok_end.l_hi}
                  - {tok_end.l_lo[FIELD_W-1], tok_end.l_lo};
    assign dden   = {tok_end.a_hi[FIELD_W-1], tok_end.a_hi}
                  - {tok_end.a_lo[FIELD_W-1], tok_end.a_lo};
    assign prod_w = dq * dl;

    assign mag        = prod_reg[33] ? 34'(-prod_reg) : 34'(prod_reg);
    assign shifted    = {rem_reg, quo_reg[FIELD_W-1]};
    assign trial      = shifted - {1'b0, den_reg};
    assign quo_signed = neg_reg ? FIELD_W'(-quo_reg) : quo_reg;

    always_comb
    begin
        state_next = state_reg;
        count_next = count_reg;
        walk_next  = walk_reg;
        step_next  = step_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_acc)
                begin
                    if (command == CMD_CLEAR)
                    begin
                        count_next = '0;
                    end
                    else if (ins.en)
                    begin
                        count_next = count_reg + CNT_W'(1);
                    end
                    else if (command == CMD_QUERY)
                    begin
                        state_next = S_WALK;
                        walk_next  = '0;
                    end
                end
            end
            S_WALK:
            begin
                walk_next = walk_reg + WALK_W'(1);
                if (walk_reg == WALK_W'(TABLE_DEPTH - 1))
                begin
                    state_next = S_MUL;
                end
            end
            S_MUL:
            begin
                if (tok_end.done && !tok_end.match && tok_end.has_prev)
                begin
                    state_next = S_PREP;
                end
                else
                begin
                    state_next = S_FIN;
                end
            end
            S_PREP:
            begin
                state_next = S_DIV;
                step_next  = '0;
            end
            S_DIV:
            begin
                step_next = step_reg + DIV_W'(1);
                if (step_reg == DIV_W'(FIELD_W - 1))
                begin
                    state_next = S_FIN;
                end
            end
            S_FIN:
            begin
                if (out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            walk_reg      <= '0;
            step_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            walk_reg  <= walk_next;
            step_reg  <= step_next;
            if ((in_acc && (command != CMD_QUERY)) || ((state_reg == S_FIN) && out_free))
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Datapath and output payload: no reset needed.
    always_ff @(posedge clk)
    begin
        if (in_acc)
        begin
            q_reg <= angle;
            if (command != CMD_QUERY)
            begin
                status_reg <= (command == CMD_INSERT && full) ? ST_FULL : ST_OK;
                lift_reg   <= '0;
                total_reg  <= 5'(count_next);
            end
        end

        unique case (state_reg)
            S_MUL:
            begin
                prod_reg <= prod_w;
                den_reg  <= dden[FIELD_W-1:0];
                quo_reg  <= '0;
                neg_reg  <= 1'b0;
                if (tok_end.done && (tok_end.match || tok_end.has_prev))
                begin
                    res_st_reg <= ST_OK;
                    base_reg   <= tok_end.l_lo;
                end
                else
                begin
                    res_st_reg <= ST_RANGE;
                    base_reg   <= '0;
                end
            end
            S_PREP:
            begin
                neg_reg <= prod_reg[33];
                rem_reg <= mag[31:16];
                quo_reg <= mag[15:0];
            end
            S_DIV:
            begin
                // Restoring step: shift in the next dividend bit, subtract if it fits.
                if (!trial[16])
                begin
                    rem_reg <= trial[FIELD_W-1:0];
                end
                else
                begin
                    rem_reg <= shifted[FIELD_W-1:0];
                end
                quo_reg <= {quo_reg[FIELD_W-2:0], !trial[16]};
            end
            S_FIN:
            begin
                if (out_free)
                begin
                    status_reg <= res_st_reg;
                    lift_reg   <= base_reg + quo_signed;
                    total_reg  <= 5'(count_reg);
                end
            end
            default:
            begin
            end
        endcase
    end

    assign out_valid   = out_valid_reg;
    assign status      = status_reg;
    assign lift_result = lift_reg;
    assign entry_total = total_reg;

    // The quotient must fit in 16 bits: high half of the dividend below the divisor.
    a_div_fits: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_PREP) |-> (mag[31:16] < den_reg))
        else $error("divider quotient overflow");

    // A bracketing pair always has strictly increasing angles.
    a_den_pos: assert property (@(posedge clk) disable iff (!rst_n)
        ((state_reg == S_MUL) && tok_end.done && !tok_end.match && tok_end.has_prev)
        |-> (dden > 0))
        else $error("bracket angles not increasing");

    a_count_max: assert property (@(posedge clk) disable iff (!rst_n)
        ins.en |=> (count_reg <= CNT_W'(TABLE_DEPTH)) && (count_reg != '0))
        else $error("point count out of bounds after insert");

    a_query_walk: assert property (@(posedge clk) disable iff (!rst_n)
        (in_acc && (command == CMD_QUERY)) |=> (state_reg == S_WALK) && !out_valid_reg
        || (state_reg == S_WALK) && $past(out_valid_reg) && $past(out_stall))
        else $error("query did not start the walk");

    a_out_source: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> ($past(in_acc) || ($past(state_reg) == S_FIN)))
        else $error("result item without a source");

endmodule

// ----- tb/sv/tb_top.sv -----
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the sorted angle/lift table with interpolating
// query. A short table of directed items covers the extremes, duplicate
// angles, the full table and out-of-range queries. Random fill-and-query
// bursts with some noise items follow. Every result item is compared
// field by field with the directed table or a local table predictor. Both
// channels idle at random, with one stretch of items that runs without gaps.
// ----------------------------------------------------------------------------
module tb_top;

    timeunit 1ns;
    timeprecision 1ps;

    import stli_pkg::*;

    localparam int DEPTH       = 16;
    localparam int ITEM_TARGET = 540;
    localparam int CYCLE_LIMIT = 400000;

    typedef struct packed {
        logic [1:0]                 status;
        logic signed [FIELD_W-1:0]  lift;
        logic [4:0]                 total;
    } lift_item_t;

    // One directed row; rep > 1 repeats it with the angle and lift stepped.
    typedef struct packed {
        logic [1:0] cmd;
        int         angle;
        int         lift;
        int         a_step;
        int         l_step;
        int         rep;
        bit         typed;
        logic [1:0] st;
        int         lres;
        int         total;
    } dir_row_t;

    logic                       clk;
    logic                       rst_n;
    logic                       in_valid;
    logic                       in_stall;
    logic [1:0]                 command;
    logic signed [FIELD_W-1:0]  angle;
    logic signed [FIELD_W-1:0]  lift_value;
    logic                       out_valid;
    logic                       out_stall;
    logic [1:0]                 status;
    logic signed [FIELD_W-1:0]  lift_result;
    logic [4:0]                 entry_total;

    // Predicted table contents
    logic signed [FIELD_W-1:0]  tbl_angle [DEPTH];
    logic signed [FIELD_W-1:0]  tbl_lift  [DEPTH];
    int                         tbl_count;

    lift_item_t                 pending_lifts [$];
    int                         errors;
    int                         items_sent;
    int                         cycles;
    bit                         steady;

    dir_row_t                   dir_rows [20];

    sorted_table_linear_interpolator_top #(.TABLE_DEPTH(DEPTH)) dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .command     (command),
        .angle       (angle),
        .lift_value  (lift_value),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .status      (status),
        .lift_result (lift_result),
        .entry_total (entry_total)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    function automatic logic [FIELD_W-1:0] rand16();
        return FIELD_W'($urandom);
    endfunction

    // Apply one item to the predicted table and return its result item.
    function automatic lift_item_t table_apply(input logic [1:0] cmd,
                                               input logic signed [FIELD_W-1:0] a,
                                               input logic signed [FIELD_W-1:0] l);
        lift_item_t r;
        int         pos;
        int         i;
        longint     num;
        longint     den;
        r = '0;
        r.status = ST_OK;
        if (cmd == CMD_CLEAR)
        begin
            tbl_count = 0;
        end
        else if (cmd == CMD_INSERT)
        begin
            if (tbl_count >= DEPTH)
            begin
                r.status = ST_FULL;
            end
            else
            begin
                pos = 0;
                while (pos < tbl_count && tbl_angle[pos] <= a)
                    pos++;
                for (i = tbl_count; i > pos; i--)
                begin
                    tbl_angle[i] = tbl_angle[i-1];
                    tbl_lift[i]  = tbl_lift[i-1];
                end
                tbl_angle[pos] = a;
                tbl_lift[pos]  = l;
                tbl_count++;
            end
        end
        else if (cmd == CMD_QUERY)
        begin
            if (tbl_count == 0 || a < tbl_angle[0] || a > tbl_angle[tbl_count-1])
            begin
                r.status = ST_RANGE;
            end
            else
            begin
                pos = -1;
                for (i = 0; i < tbl_count; i++)
                    if (pos < 0 && tbl_angle[i] == a)
                        pos = i;
                if (pos >= 0)
                begin
                    r.lift = tbl_lift[pos];
                end
                else
                begin
                    // first point above the query angle
                    i = 1;
                    while (i < tbl_count && tbl_angle[i] <= a)
                        i++;
                    num = (longint'(a) - longint'(tbl_angle[i-1])) *
                          (longint'(tbl_lift[i]) - longint'(tbl_lift[i-1]));
                    den = longint'(tbl_angle[i]) - longint'(tbl_angle[i-1]);
                    r.lift = FIELD_W'(longint'(tbl_lift[i-1]) + num / den);
                end
            end
        end
        r.total = 5'(tbl_count);
        return r;
    endfunction

    // Offer one item, hold it until taken, then record what it must produce.
    task automatic send_item(input logic [1:0] cmd,
                             input logic [FIELD_W-1:0] a,
                             input logic [FIELD_W-1:0] l,
                             input bit typed = 1'b0,
                             input lift_item_t want = '0);
        lift_item_t r;
        lift_item_t exp_new;
        while (!steady && $urandom_range(99) < 34)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid   <= 1'b1;
        command    <= cmd;
        angle      <= a;
        lift_value <= l;
        do
            @(posedge clk);
        while (in_stall);
        r = table_apply(cmd, a, l);
        exp_new = typed ? want : r;
        pending_lifts = {pending_lifts, exp_new};
        items_sent++;
    endtask

    // Fill the table, mostly from empty, then query it.
    task automatic fill_and_query();
        int                        n_ins;
        int                        n_q;
        int                        mode;
        int                        k;
        int                        pick;
        int                        lo;
        int                        hi;
        logic [FIELD_W-1:0]        base;
        logic [FIELD_W-1:0]        a;
        if ($urandom_range(99) < 85)
            send_item(CMD_CLEAR, rand16(), rand16());
        n_ins = ($urandom_range(9) == 0) ? $urandom_range(19, 15) : $urandom_range(8, 1);
        mode  = $urandom_range(2);
        base  = rand16();
        for (k = 0; k < n_ins; k++)
        begin
            case (mode)
                0: a = rand16();
                1: a = base + FIELD_W'($urandom_range(200)) - FIELD_W'(100);
                default: a = base + FIELD_W'(256 * $urandom_range(4));
            endcase
            send_item(CMD_INSERT, a, rand16());
        end
        n_q = $urandom_range(8, 2);
        for (k = 0; k < n_q; k++)
        begin
            pick = $urandom_range(9);
            a = rand16();
            if (tbl_count > 0)
            begin
                lo = tbl_angle[0];
                hi = tbl_angle[tbl_count-1];
                if (pick < 5)
                    a = FIELD_W'(lo + int'($urandom_range(hi - lo)));
                else if (pick < 7)
                    a = tbl_angle[$urandom_range(tbl_count - 1)];
                else if (pick < 8)
                    a = (lo > -32768) ? FIELD_W'(lo - 1) : FIELD_W'(hi + 1);
            end
            send_item(CMD_QUERY, a, rand16());
        end
    endtask

    // Receiver stalls at random outside the steady stretch.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_stall <= 1'b0;
        else
            out_stall <= !steady && ($urandom_range(99) < 34);
    end

    always @(posedge clk)
    begin
        lift_item_t exp_item;
        if (rst_n && out_valid && !out_stall)
        begin
            if (pending_lifts.size() == 0)
            begin
                $display("%0t: unexpected result item status=%0d lift=%0d total=%0d",
                         $time, status, lift_result, entry_total);
                errors++;
            end
            else
            begin
                exp_item = pending_lifts.pop_front();
                if (status !== exp_item.status)
                begin
                    $display("%0t: status expected %0d actual %0d",
                             $time, exp_item.status, status);
                    errors++;
                end
                if (lift_result !== exp_item.lift)
                begin
                    $display("%0t: lift_result expected %0d actual %0d",
                             $time, exp_item.lift, lift_result);
                    errors++;
                end
                if (entry_total !== exp_item.total)
                begin
                    $display("%0t: entry_total expected %0d actual %0d",
                             $time, exp_item.total, entry_total);
                    errors++;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles == CYCLE_LIMIT)
        begin
            $display("%0t: timeout with %0d result items outstanding",
                     $time, pending_lifts.size());
            $display("CHECK FAILED");
            $finish;
        end
    end

    initial
    begin
        int         k;
        lift_item_t want;
        rst_n      = 1'b0;
        in_valid   = 1'b0;
        command    = CMD_NOP;
        angle      = '0;
        lift_value = '0;
        errors     = 0;
        items_sent = 0;
        cycles     = 0;
        steady     = 1'b0;
        tbl_count  = 0;

        //             cmd         angle   lift   astep  lstep rep typed status   lres  total
        dir_rows[0]  = '{CMD_QUERY,      0,      0,     0,    0, 1, 1, ST_RANGE,      0,  0};
        dir_rows[1]  = '{CMD_NOP,     4660,  22136,     0,    0, 1, 1, ST_OK,         0,  0};
        dir_rows[2]  = '{CMD_INSERT, -32768, 32767,     0,    0, 1, 1, ST_OK,         0,  1};
        dir_rows[3]  = '{CMD_INSERT,  32767,-32768,     0,    0, 1, 1, ST_OK,         0,  2};
        dir_rows[4]  = '{CMD_QUERY,  -32768,     0,     0,    0, 1, 1, ST_OK,     32767,  2};
        dir_rows[5]  = '{CMD_QUERY,   32767,     0,     0,    0, 1, 1, ST_OK,    -32768,  2};
        dir_rows[6]  = '{CMD_QUERY,       0,     0,     0,    0, 1, 0, ST_OK,         0,  0};
        // duplicate angle goes after the first; exact query keeps the first
        dir_rows[7]  = '{CMD_INSERT, -32768,  4096,     0,    0, 1, 1, ST_OK,         0,  3};
        dir_rows[8]  = '{CMD_QUERY,  -32768,     0,     0,    0, 1, 1, ST_OK,     32767,  3};
        dir_rows[9]  = '{CMD_QUERY,  -32767,     0,     0,    0, 1, 0, ST_OK,         0,  0};
        dir_rows[10] = '{CMD_CLEAR,       5,     7,     0,    0, 1, 1, ST_OK,         0,  0};
        dir_rows[11] = '{CMD_QUERY,     100,     0,     0,    0, 1, 1, ST_RANGE,      0,  0};
        // fill in descending angle order so every insert shifts the table
        dir_rows[12] = '{CMD_INSERT,  10500,-30000, -1500, 4000,16, 0, ST_OK,         0,  0};
        dir_rows[13] = '{CMD_INSERT,      0,     0,     0,    0, 1, 1, ST_FULL,       0, 16};
        dir_rows[14] = '{CMD_QUERY,  -12001,     0,     0,    0, 1, 1, ST_RANGE,      0, 16};
        dir_rows[15] = '{CMD_QUERY,   10501,     0,     0,    0, 1, 1, ST_RANGE,      0, 16};
        dir_rows[16] = '{CMD_QUERY,  -11999,     0,     0,    0, 1, 0, ST_OK,         0,  0};
        dir_rows[17] = '{CMD_QUERY,   10499,     0,     0,    0, 1, 0, ST_OK,         0,  0};
        dir_rows[18] = '{CMD_QUERY,     777,     0,     0,    0, 1, 0, ST_OK,         0,  0};
        dir_rows[19] = '{CMD_CLEAR,      -1,    -1,     0,    0, 1, 1, ST_OK,         0,  0};

        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (dir_rows[r])
        begin
            for (k = 0; k < dir_rows[r].rep; k++)
            begin
                want.status = dir_rows[r].st;
                want.lift   = FIELD_W'(dir_rows[r].lres);
                want.total  = 5'(dir_rows[r].total);
                send_item(dir_rows[r].cmd,
                          FIELD_W'(dir_rows[r].angle + k * dir_rows[r].a_step),
                          FIELD_W'(dir_rows[r].lift + k * dir_rows[r].l_step),
                          dir_rows[r].typed, want);
            end
        end

        while (items_sent < ITEM_TARGET)
        begin
            steady = (items_sent >= 250 && items_sent < 340);
            if ($urandom_range(99) < 80)
            begin
                fill_and_query();
            end
            else
            begin
                repeat ($urandom_range(4, 1))
                    send_item(2'($urandom_range(3)), rand16(), rand16());
            end
        end
        in_valid <= 1'b0;

        while (pending_lifts.size() != 0)
            @(posedge clk);
        repeat (DEPTH + 25) @(posedge clk);
        if (errors == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule
